[rtl/sha_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; used by every module under rtl.
package sha_pkg;

    localparam int        COUNT_W  = 61;
    localparam int        ROUNDS   = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef logic [31:0]  word_t;
    typedef word_t [7:0]  hash_arr_t;
    typedef word_t [15:0] window_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    // what follows a compression
    typedef enum logic [1:0] {
        NX_IDLE,
        NX_PAD,
        NX_LEN,
        NX_EMIT
    } next_step_t;

    typedef struct packed {
        logic        wr;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic        len_wr;
        logic [63:0] len;
        logic        shift;
        logic        clear;
    } sched_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } round_ctrl_t;

    function automatic word_t big_s0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_s1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_s0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_s1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic hash_arr_t init_hash();
        hash_arr_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        return h;
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

[rtl/sha_sched.sv]
// Message block window and on-the-fly message schedule.
// Depends on sha_pkg (window type, control struct, sigma functions).
module sha_sched
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sched_ctrl_t ctrl,
    output word_t       w_head
);

    window_t    window_reg;
    window_t    window_next;
    word_t      w_new;
    logic [1:0] lane;

    // word sixteen rounds ahead of the head
    assign w_new = small_s1(window_reg[14]) + window_reg[9]
                 + small_s0(window_reg[1]) + window_reg[0];

    // big-endian: byte 0 of a word sits in the top lane
    assign lane = 2'd3 - ctrl.pos[1:0];

    always_comb
    begin
        window_next = window_reg;
        if (ctrl.clear)
        begin
            window_next = '0;
        end
        else if (ctrl.shift)
        begin
            // advance one round: drop the head, append the next schedule word
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[15] = w_new;
        end
        else
        begin
            if (ctrl.wr)
            begin
                window_next[ctrl.pos[5:2]][{lane, 3'b000} +: 8] = ctrl.data;
            end
            if (ctrl.len_wr)
            begin
                window_next[14] = ctrl.len[63:32];
                window_next[15] = ctrl.len[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    assign w_head = window_reg[0];

endmodule

[rtl/sha_round.sv]
// Working variables and the shared SHA-256 round unit, one round per cycle while step is set.
// Depends on sha_pkg (hash array type, round functions).
module sha_round
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  round_ctrl_t ctrl,
    input  hash_arr_t   hash,
    input  word_t       k,
    input  word_t       w,
    output hash_arr_t   vars
);

    hash_arr_t vars_reg;
    hash_arr_t vars_next;
    word_t     t1;
    word_t     t2;

    assign t1 = vars_reg[7] + big_s1(vars_reg[4])
              + choose(vars_reg[4], vars_reg[5], vars_reg[6]) + k + w;
    assign t2 = big_s0(vars_reg[0]) + majority(vars_reg[0], vars_reg[1], vars_reg[2]);

    always_comb
    begin
        vars_next = vars_reg;
        if (ctrl.load)
        begin
            vars_next = hash;
        end
        else if (ctrl.step)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vars_reg <= '0;
        end
        else
        begin
            vars_reg <= vars_next;
        end
    end

    assign vars = vars_reg;

endmodule

[rtl/sha256_stream_hasher_top.sv]
// Top level of the SHA-256 stream hasher: sequencer, hash words, byte count.
// Depends on sha_pkg, sha_sched and sha_round.
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+------------------------------------
//  message  | msg_valid     | msg_stall     | msg_byte, byte_valid, end_of_message
//  digest   | digest_valid  | digest_stall  | digest_word, word_index, last_word
//
// Completing a 64-byte block starts a compression: 64 rounds of the shared round
// unit plus the hash update. Closing a message costs one or two further
// compressions, each after a state that writes the padding or the length, then
// eight digest words, one per cycle unless stalled.
// msg_stall is high whenever the sequencer is not idle. Reset is asynchronous
// and needs no clearing pass.
module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  msg_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    state_t             state_reg;
    state_t             state_next;
    next_step_t         after_reg;
    next_step_t         after_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [5:0]         round_reg;
    logic [5:0]         round_next;
    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;
    hash_arr_t          hash_reg;
    hash_arr_t          hash_next;
    hash_arr_t          vars;
    logic               hash_add;
    logic               hash_init;
    sched_ctrl_t        sc;
    round_ctrl_t        rc;
    word_t              w_head;

    sha_sched u_sched (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sc),
        .w_head (w_head)
    );

    sha_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rc),
        .hash  (hash_reg),
        .k     (round_k(round_reg)),
        .w     (w_head),
        .vars  (vars)
    );

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        count_next = count_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        hash_add   = 1'b0;
        hash_init  = 1'b0;
        sc         = '0;
        rc         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (byte_valid)
                    begin
                        sc.wr      = 1'b1;
                        sc.pos     = count_reg[5:0];
                        sc.data    = msg_byte;
                        count_next = count_reg + 1'b1;
                    end
                    if (byte_valid && (count_reg[5:0] == LAST_BYTE))
                    begin
                        // block full: compress, then close the message if asked
                        rc.load    = 1'b1;
                        round_next = '0;
                        state_next = ST_ROUND;
                        after_next = end_of_message ? NX_PAD : NX_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                rc.step    = 1'b1;
                sc.shift   = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                hash_add = 1'b1;
                sc.clear = 1'b1;
                idx_next = '0;
                unique case (after_reg)
                    NX_IDLE: state_next = ST_IDLE;
                    NX_PAD:  state_next = ST_PAD;
                    NX_LEN:  state_next = ST_LEN;
                    NX_EMIT: state_next = ST_EMIT;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PAD:
            begin
                sc.wr      = 1'b1;
                sc.pos     = count_reg[5:0];
                sc.data    = PAD_BYTE;
                rc.load    = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
                if (count_reg[5:0] >= LEN_POS)
                begin
                    // no room for the length: it goes in an extra block
                    after_next = NX_LEN;
                end
                else
                begin
                    sc.len_wr  = 1'b1;
                    sc.len     = {count_reg, 3'b000};
                    after_next = NX_EMIT;
                end
            end
            ST_LEN:
            begin
                sc.len_wr  = 1'b1;
                sc.len     = {count_reg, 3'b000};
                rc.load    = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
                after_next = NX_EMIT;
            end
            ST_EMIT:
            begin
                if (!digest_stall)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_WORD)
                    begin
                        hash_init  = 1'b1;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (hash_init)
        begin
            hash_next = init_hash();
        end
        else if (hash_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + vars[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= NX_IDLE;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            hash_reg  <= init_hash();
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            hash_reg  <= hash_next;
        end
    end

    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_EMIT);
    assign digest_word  = hash_reg[idx_reg];
    assign word_index   = idx_reg;
    assign last_word    = (idx_reg == LAST_WORD);

endmodule

[sim/sha256_stream_hasher_top_test.sv]
// Self-checking testbench for sha256_stream_hasher_top: drives message requests, predicts
// each digest with its own SHA-256 model and checks every digest word in order.
// Depends on sha_pkg and the RTL under rtl; needs no files or arguments.
module sha256_stream_hasher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::word_t;

    localparam int         HALF_PERIOD   = 10;
    localparam int         RESET_CYCLES  = 8;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         STUCK_LIMIT   = 4000;
    localparam int         PHASE_ITEMS   = 70;
    localparam int         SETTLE_CYCLES = 20;
    localparam logic [7:0] PAD_MARK      = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       closes;
    } msg_req_t;

    typedef struct packed {
        word_t      word_val;
        logic [2:0] slot;
        logic       is_last;
    } digest_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic [7:0]  msg_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    word_t k_const [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    word_t h_init [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predictor state
    word_t       hash_state [8];
    word_t       block_words [16];
    logic [60:0] msg_len;

    msg_req_t    pending_reqs [$];
    digest_exp_t expected_words [$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit msg_took      = 1'b0;
    bit hold_armed    = 1'b0;
    bit hold_digest   = 1'b0;

    sha256_stream_hasher_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .msg_byte       (msg_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block;
        word_t w [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = block_words[t];
        end
        for (int t = 16; t < 64; t++)
        begin
            w[t] = w[t-16] + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        v = hash_state;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = hash_state[i] + v[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            block_words[i] = '0;
        end
    endtask

    task automatic place_byte(input logic [5:0] pos, input logic [7:0] data);
        block_words[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = data;
    endtask

    // Advance the model by one accepted request; queue the eight words on a close.
    task automatic hash_request(input logic [7:0] data, input logic has_byte,
                                input logic closes);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        digest_exp_t e;
        if (has_byte)
        begin
            place_byte(msg_len[5:0], data);
            msg_len = msg_len + 1'b1;
            if (msg_len[5:0] == 6'd0)
                compress_block();
        end
        if (closes)
        begin
            pos = msg_len[5:0];
            place_byte(pos, PAD_MARK);
            for (int i = pos + 1; i < 64; i++)
            begin
                place_byte(6'(i), 8'h00);
            end
            // no room for the length: spill into a second final block
            if (pos >= 6'd56)
                compress_block();
            bit_len = {msg_len, 3'b000};
            block_words[14] = bit_len[63:32];
            block_words[15] = bit_len[31:0];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                e.word_val = hash_state[i];
                e.slot     = 3'(i);
                e.is_last  = (i == 7);
                expected_words.insert(expected_words.size(), e);
            end
            hash_state = h_init;
            msg_len    = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic queue_req(input logic [7:0] data, input logic has_byte,
                             input logic closes);
        msg_req_t r;
        r.data     = data;
        r.has_byte = has_byte;
        r.closes   = closes;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // One message with random content; the close rides on the last byte or stands alone.
    task automatic queue_message(input int len, inout int counted);
        bit close_with_byte;
        close_with_byte = (len != 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 6)
                queue_req(8'($urandom), 1'b0, 1'b0);
            queue_req(8'($urandom), 1'b1, close_with_byte && (i == len - 1));
            counted++;
        end
        if (!close_with_byte)
        begin
            queue_req(8'($urandom), 1'b0, 1'b1);
            counted++;
        end
    endtask

    task automatic wait_for_drain;
        while (pending_reqs.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        digest_exp_t want;
        if (rst_n)
        begin
            if (digest_valid && !digest_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("digest word with nothing outstanding", digest_word, '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (digest_word !== want.word_val)
                        report_mismatch("digest_word", digest_word, want.word_val);
                    if (word_index !== want.slot)
                        report_mismatch("word_index", 32'(word_index), 32'(want.slot));
                    if (last_word !== want.is_last)
                        report_mismatch("last_word", 32'(last_word), 32'(want.is_last));
                end
            end
            if (msg_valid && !msg_stall)
            begin
                hash_request(msg_byte, byte_valid, end_of_message);
                msg_took = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        bit taken;
        taken = msg_took;
        if (taken)
        begin
            void'(pending_reqs.pop_front());
            msg_took = 1'b0;
        end
        // hold a request that is still waiting
        if (!(msg_valid && !taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                msg_valid      <= 1'b1;
                msg_byte       <= pending_reqs[0].data;
                byte_valid     <= pending_reqs[0].has_byte;
                end_of_message <= pending_reqs[0].closes;
            end
            else
            begin
                msg_valid <= 1'b0;
            end
        end
        digest_stall <= hold_digest || ($urandom_range(99) < stall_pct);
    end

    // Long hold-off on the digest side so the block backs up into its input.
    initial
    begin : receiver_hold
        wait (hold_armed);
        @(posedge clk);
        hold_digest = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_digest = 1'b0;
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((msg_valid && !msg_stall) || (digest_valid && !digest_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int len;
        hash_state = h_init;
        for (int i = 0; i < 16; i++)
        begin
            block_words[i] = '0;
        end
        msg_len = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // empty message, stray byte value ignored
        queue_req(8'hff, 1'b0, 1'b1);
        // "abc", close on the last byte
        queue_req(8'h61, 1'b1, 1'b0);
        queue_req(8'h62, 1'b1, 1'b0);
        queue_req(8'h63, 1'b1, 1'b1);
        // idle request between messages
        queue_req(8'ha5, 1'b0, 1'b0);
        // byte extremes, separate close
        queue_req(8'h00, 1'b1, 1'b0);
        queue_req(8'hff, 1'b1, 1'b0);
        queue_req(8'h5a, 1'b0, 1'b1);
        queue_req(8'hff, 1'b1, 1'b1);
        // idle request inside a message
        queue_req(8'h12, 1'b1, 1'b0);
        queue_req(8'hc3, 1'b0, 1'b0);
        queue_req(8'h34, 1'b1, 1'b1);
        wait_for_drain();

        sent = 0;
        hold_armed = 1'b1;
        for (int m = 0; m < 3; m++)
        begin
            queue_message($urandom_range(12, 5), sent);
        end
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // favour short messages and the block and padding boundaries
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8: len = $urandom_range(8);
                    9:  len = 55;
                    10: len = 56;
                    11: len = 57;
                    12: len = 63;
                    13: len = 64;
                    14: len = 65;
                    15: len = 120;
                    default: len = $urandom_range(70, 9);
                endcase
                queue_message(len, sent);
            end
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
